[rtl/iqsp_pkg.sv]
// ----------------------------------------------------------------------------
// iqsp_pkg: shared constants for the I/Q sample projector
// CORDIC step count, angle table and log-to-dB constants.
// ----------------------------------------------------------------------------
package iqsp_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int CNT_W         = $clog2(CORDIC_STAGES);
  localparam int LOG_FRAC      = 24;
  // 10*log10(2) in Q30
  localparam logic signed [32:0] DB_COEF = 33'sd3232284966;

  // atan(2^-i) as a binary angle, 2^31 = pi
  function automatic logic [31:0] atan_angle(input logic [4:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:    a = 32'd536870912;
      5'd1:    a = 32'd316933406;
      5'd2:    a = 32'd167458907;
      5'd3:    a = 32'd85004756;
      5'd4:    a = 32'd42667331;
      5'd5:    a = 32'd21354465;
      5'd6:    a = 32'd10679838;
      5'd7:    a = 32'd5340245;
      5'd8:    a = 32'd2670163;
      5'd9:    a = 32'd1335087;
      5'd10:   a = 32'd667544;
      5'd11:   a = 32'd333772;
      5'd12:   a = 32'd166886;
      5'd13:   a = 32'd83443;
      5'd14:   a = 32'd41721;
      5'd15:   a = 32'd20860;
      5'd16:   a = 32'd10430;
      5'd17:   a = 32'd5215;
      5'd18:   a = 32'd2607;
      5'd19:   a = 32'd1303;
      5'd20:   a = 32'd651;
      5'd21:   a = 32'd325;
      5'd22:   a = 32'd162;
      5'd23:   a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

[rtl/iqsp_cordic.sv]
// ----------------------------------------------------------------------------
// iqsp_cordic: iterative vectoring CORDIC
// One micro-rotation per cycle through a shared shifter per axis; angle out in (-pi, pi].
// ----------------------------------------------------------------------------
module iqsp_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] re,
  input  logic signed [15:0] im,
  output logic               done,
  output logic signed [32:0] angle
);
  import iqsp_pkg::*;

  localparam logic signed [33:0] PI_A   = 34'sh0_8000_0000;
  localparam logic signed [33:0] HALF_A = 34'sh0_4000_0000;
  localparam logic signed [33:0] TWO_PI = 34'sh1_0000_0000;

  logic                    busy;
  logic        [CNT_W-1:0] cnt;
  logic signed [35:0]      x, y;
  logic signed [33:0]      z;

  logic signed [35:0] x0, y0, xi, yi, xs, ys, x_next, y_next;
  logic signed [33:0] zi, at, z_next, z_wrap;

  always_comb begin
    x0 = {{5{re[15]}}, re, 15'b0};
    y0 = {{5{im[15]}}, im, 15'b0};
    xi = x0;
    yi = y0;
    zi = '0;
    if (x0 < 0) begin
      if (y0 >= 0) begin
        xi = y0;
        yi = -x0;
        zi = HALF_A;
      end else begin
        xi = -y0;
        yi = x0;
        zi = -HALF_A;
      end
    end
    xs = x >>> cnt;
    ys = y >>> cnt;
    at = {2'b00, atan_angle(5'(cnt))};
    if (y >= 0) begin
      x_next = x + ys;
      y_next = y - xs;
      z_next = z + at;
    end else begin
      x_next = x - ys;
      y_next = y + xs;
      z_next = z - at;
    end
    if (z_next > PI_A)
      z_wrap = z_next - TWO_PI;
    else if (z_next <= -PI_A)
      z_wrap = z_next + TWO_PI;
    else
      z_wrap = z_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (re == 16'sd0 && im == 16'sd0) begin
          // zero sample: phase taken as 0
          angle <= '0;
          done  <= 1'b1;
        end else begin
          x    <= xi;
          y    <= yi;
          z    <= zi;
          cnt  <= '0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        x   <= x_next;
        y   <= y_next;
        z   <= z_next;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(CORDIC_STAGES - 1)) begin
          busy  <= 1'b0;
          done  <= 1'b1;
          angle <= z_wrap[32:0];
        end
      end
    end
  end

endmodule

[rtl/iqsp_sqrt.sv]
// ----------------------------------------------------------------------------
// iqsp_sqrt: iterative integer square root
// One result bit per cycle, floor of the exact root.
// ----------------------------------------------------------------------------
module iqsp_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [33:0] val,
  output logic        done,
  output logic [16:0] root
);
  import iqsp_pkg::*;

  logic        busy;
  logic [4:0]  k;
  logic [33:0] x;
  logic [34:0] r;

  logic [34:0] bitv, trial, r_next;
  logic        take;

  always_comb begin
    bitv   = 35'd1 << {k, 1'b0};
    trial  = r + bitv;
    take   = {1'b0, x} >= trial;
    r_next = take ? ((r >> 1) + bitv) : (r >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      k    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x    <= val;
        r    <= '0;
        k    <= 5'd16;
        busy <= 1'b1;
      end else if (busy) begin
        if (take)
          x <= x - trial[33:0];
        r <= r_next;
        k <= k - 1'b1;
        if (k == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
          root <= r_next[16:0];
        end
      end
    end
  end

endmodule

[rtl/iqsp_log.sv]
// ----------------------------------------------------------------------------
// iqsp_log: power to dB through log2 by repeated squaring
// Normalize one bit a cycle, then one shared 31x31 squarer per fraction bit.
// ----------------------------------------------------------------------------
module iqsp_log (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        pwr,
  output logic               done,
  output logic signed [25:0] db
);
  import iqsp_pkg::*;

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_NORM = 3'd1;
  localparam logic [2:0] L_SQ   = 3'd2;
  localparam logic [2:0] L_UPD  = 3'd3;
  localparam logic [2:0] L_MUL  = 3'd4;
  localparam logic [2:0] L_OUT  = 3'd5;

  localparam logic signed [64:0] RND = 65'sd1 <<< 37;

  logic [2:0]  state;
  logic [31:0] mw;
  logic [4:0]  n;
  logic [30:0] m;
  logic [61:0] prod;
  logic [LOG_FRAC-1:0] frac;
  logic [4:0]  cnt;
  logic signed [64:0] prod2;

  logic [31:0]        t;
  logic signed [6:0]  ne;
  logic signed [31:0] lg;
  logic signed [64:0] rnd;

  always_comb begin
    t   = prod[61:30];
    ne  = $signed({2'b00, n}) - 7'sd30;
    lg  = {ne[6], ne, frac};
    rnd = (prod2 + RND) >>> 38;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        L_IDLE: begin
          if (start) begin
            mw    <= pwr;
            n     <= 5'd31;
            cnt   <= '0;
            state <= L_NORM;
          end
        end
        L_NORM: begin
          if (mw[31]) begin
            m     <= mw[31:1];
            state <= L_SQ;
          end else begin
            mw <= mw << 1;
            n  <= n - 1'b1;
          end
        end
        L_SQ: begin
          prod  <= m * m;
          state <= L_UPD;
        end
        L_UPD: begin
          frac <= {frac[LOG_FRAC-2:0], t[31]};
          m    <= t[31] ? t[31:1] : t[30:0];
          cnt  <= cnt + 1'b1;
          state <= (cnt == 5'(LOG_FRAC - 1)) ? L_MUL : L_SQ;
        end
        L_MUL: begin
          prod2 <= lg * DB_COEF;
          state <= L_OUT;
        end
        L_OUT: begin
          db    <= rnd[25:0];
          done  <= 1'b1;
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

[rtl/iq_sample_projector.sv]
// ----------------------------------------------------------------------------
// iq_sample_projector: I/Q sample to projected value (Q8.16, saturated)
// Sequencer around the CORDIC, square root and log units plus output stage.
// ----------------------------------------------------------------------------
// Path: accept in idle, square, sum to power, then run a unit or go straight to
//   the output stage: real, imag, magsq and zero dB need no unit; magnitude uses
//   the square root (17 root steps), phase modes the CORDIC (16 CORDIC steps, none
//   for a zero sample), dB the log unit (1 to 32 normalize steps, 24 squarings).
// One sample at a time: a held output stalls the sequencer; the next sample is
//   taken once the last result is in the output register, while it still waits.
// Reset: synchronous; mode returns to real, phase history to 0, outputs empty.
// ----------------------------------------------------------------------------
module iq_sample_projector (
  input  logic        clk,
  input  logic        rst,
  // config channel: projection_mode
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] sample_real, [31:16] sample_imag
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [23:0] projected_value
  output logic [0:0]  m_tuser    // [0] value_saturated
);
  import iqsp_pkg::*;

  // mode codes
  localparam logic [3:0] MODE_REAL  = 4'd0;
  localparam logic [3:0] MODE_IMAG  = 4'd1;
  localparam logic [3:0] MODE_MAG   = 4'd2;
  localparam logic [3:0] MODE_MAGSQ = 4'd3;
  localparam logic [3:0] MODE_DB    = 4'd4;
  localparam logic [3:0] MODE_PHASE = 4'd5;
  localparam logic [3:0] MODE_DPH   = 4'd6;
  localparam logic [3:0] MODE_BPSK  = 4'd7;
  localparam logic [3:0] MODE_QPSK  = 4'd8;
  localparam logic [3:0] MODE_8PSK  = 4'd9;
  localparam logic [3:0] MODE_16PSK = 4'd10;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_GO   = 3'd3;
  localparam logic [2:0] ST_RUN  = 3'd4;
  localparam logic [2:0] ST_CALC = 3'd5;

  localparam logic signed [33:0] PI_A   = 34'sh0_8000_0000;
  localparam logic signed [33:0] TWO_PI = 34'sh1_0000_0000;
  localparam logic signed [33:0] OUT_MX = 34'sd8388607;
  localparam logic signed [33:0] OUT_MN = -34'sd8388608;

  // binary angle (2^31 = pi) to Q8.16, round half up
  function automatic logic signed [33:0] ang_out(input logic signed [33:0] a);
    return (a + 34'sd16384) >>> 15;
  endfunction

  logic [2:0]         state;
  logic [3:0]         mode;
  logic signed [15:0] prev_phase;
  logic signed [15:0] re, im;
  logic [31:0]        sqr, sqi;
  logic [31:0]        p;

  // unit handshakes
  logic               c_start, s_start, l_start;
  logic               c_done, s_done, l_done;
  logic signed [32:0] angle;
  logic [16:0]        root;
  logic signed [25:0] db;

  logic signed [33:0] za, d0, dw, v;
  logic signed [33:0] psk, base, off, ye, hm, w, u;
  logic [36:0]        zsh;
  logic [31:0]        ylow;
  logic signed [32:0] y33;
  logic [2:0]         b;
  logic [33:0]        wsh;
  logic [5:0]         j, mcnt;
  logic [33:0]        ps;
  logic               sat, zero_db, out_free;
  logic               need_unit;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign zero_db   = (p == 32'd0);

  always_comb begin
    need_unit = 1'b0;
    case (mode) inside
      MODE_MAG:                  need_unit = 1'b1;
      MODE_DB:                   need_unit = !zero_db;
      [MODE_PHASE:MODE_16PSK]:   need_unit = 1'b1;
      default:                   need_unit = 1'b0;
    endcase
  end

  assign s_start = (state == ST_GO) && (mode == MODE_MAG);
  assign l_start = (state == ST_GO) && (mode == MODE_DB) && !zero_db;
  assign c_start = (state == ST_GO) && (mode >= MODE_PHASE) && (mode <= MODE_16PSK);

  iqsp_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (c_start),
    .re    (re),
    .im    (im),
    .done  (c_done),
    .angle (angle)
  );

  iqsp_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (s_start),
    .val   ({p, 2'b00}),
    .done  (s_done),
    .root  (root)
  );

  iqsp_log u_log (
    .clk   (clk),
    .rst   (rst),
    .start (l_start),
    .pwr   (p),
    .done  (l_done),
    .db    (db)
  );

  // projection arithmetic on registered unit results
  always_comb begin
    za = {angle[32], angle};

    // phase step against history, wrapped to [-pi, pi]
    d0 = za - {{2{prev_phase[15]}}, prev_phase, 16'b0};
    if (d0 < -PI_A)
      dw = d0 + TWO_PI;
    else if (d0 > PI_A)
      dw = d0 - TWO_PI;
    else
      dw = d0;

    // PSK fold: b = log2 of symbol count
    b    = 3'(mode - MODE_DPH);
    zsh  = {{4{angle[32]}}, angle} << b;
    ylow = zsh[31:0];
    y33  = (ylow == 32'h8000_0000) ? 33'sh0_8000_0000 : {ylow[31], ylow};
    ye   = {y33[32], y33};
    // divide toward zero
    base = (ye + (y33[32] ? ((34'sd1 <<< b) - 34'sd1) : 34'sd0)) >>> b;
    u    = 34'sd1 <<< (6'd31 - {3'd0, b});
    hm   = PI_A - u;
    w    = za + hm;
    wsh  = w >>> (6'd32 - {3'd0, b});
    j    = wsh[5:0] + 6'd2;
    mcnt = 6'd1 << b;
    if (w < 0)
      off = -hm;
    else if (j <= mcnt)
      off = -hm + ({28'd0, j - 6'd1} <<< (6'd32 - {3'd0, b}));
    else if (za < PI_A)
      off = -hm;
    else
      off = '0;
    psk = base + off;

    ps = ({2'b00, p} + 34'd8192) >> 14;

    case (mode) inside
      MODE_IMAG:  v = {{17{im[15]}}, im, 1'b0};
      MODE_MAG:   v = {17'd0, root};
      MODE_MAGSQ: v = ps;
      MODE_DB:    v = zero_db ? OUT_MN : {{8{db[25]}}, db};
      MODE_PHASE: v = ang_out(za);
      MODE_DPH:   v = ang_out(dw);
      [MODE_BPSK:MODE_16PSK]: v = ang_out(psk);
      default:    v = {{17{re[15]}}, re, 1'b0};
    endcase
    sat = (mode == MODE_DB && zero_db) || (v > OUT_MX) || (v < OUT_MN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      mode       <= MODE_REAL;
      prev_phase <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid)
        mode <= cfg_data;
      // the output stage reloads itself in ST_CALC
      if (m_tvalid && m_tready && state != ST_CALC)
        m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            re    <= s_tdata[15:0];
            im    <= s_tdata[31:16];
            state <= ST_SQ;
          end
        end
        ST_SQ: begin
          sqr   <= 32'(re * re);
          sqi   <= 32'(im * im);
          state <= ST_SUM;
        end
        ST_SUM: begin
          p     <= sqr + sqi;
          state <= ST_GO;
        end
        ST_GO: begin
          state <= need_unit ? ST_RUN : ST_CALC;
        end
        ST_RUN: begin
          if (c_done || s_done || l_done)
            state <= ST_CALC;
        end
        ST_CALC: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= sat;
            if (v > OUT_MX)
              m_tdata <= OUT_MX[23:0];
            else if (v < OUT_MN)
              m_tdata <= OUT_MN[23:0];
            else
              m_tdata <= v[23:0];
            if (mode == MODE_DPH)
              prev_phase <= 16'((za + 34'sd32768) >>> 16);
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
